/* src/crc8fr_pkg.sv */
// Shared types, constants and the CRC-8 step function for the CRC-8 frame receiver.
// Depends on nothing; the controller, datapath and top level import it.
package crc8fr_pkg;

    // Largest payload a frame may carry, in bytes.
    localparam int MAX_PAYLOAD = 16;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);

    // Output field widths.
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int POS_W    = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC_VALUE  = 2'd0;
    localparam logic [1:0] REG_CRC_SEED    = 2'd1;
    localparam logic [1:0] REG_SWITCH_TYPE = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] SYNC_VALUE_RST  = 8'hAA;
    localparam logic [7:0] CRC_SEED_RST    = 8'hFF;
    localparam logic [7:0] SWITCH_TYPE_RST = 8'h10;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN = 2'd2;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_kind;       // latch the type byte
        logic ld_len;        // latch the length, reset fill position and CRC
        logic ld_byte;       // store a payload byte and advance the CRC
        logic start_replay;  // rewind the replay pointer
        logic emit_bad_len;  // load a bad-length result
        logic emit_crc_err;  // load a CRC-mismatch result
        logic emit_byte;     // load the next replayed payload byte
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync_hit;      // incoming byte equals the sync value
        logic len_bad;       // incoming length is zero or too large
        logic len_full;      // this payload byte is the frame's last
        logic crc_match;     // incoming byte equals the running CRC
        logic replay_last;   // replay pointer is at the final payload byte
        logic out_free;      // output register can take a word this cycle
    } dp_stat_t;

    // One byte through CRC-8, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* src/crc8fr_ctrl.sv */
// Frame parsing state machine of the CRC-8 frame receiver.
// Depends on crc8fr_pkg for the command and status structs.
module crc8fr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  crc8fr_pkg::dp_stat_t   stat,
    output crc8fr_pkg::ctrl_cmd_t  cmd
);
    import crc8fr_pkg::*;

    localparam logic [2:0] PH_SYNC    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;
    localparam logic [2:0] PH_REPLAY  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc;

    // A word is taken only when the output register can absorb any result it causes.
    assign s_ready = (state_reg != PH_REPLAY) && stat.out_free;
    assign acc     = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            PH_SYNC: begin
                if (acc && stat.sync_hit) begin
                    state_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (acc) begin
                    cmd.ld_kind = 1'b1;
                    state_next  = PH_LEN;
                end
            end
            PH_LEN: begin
                if (acc) begin
                    if (stat.len_bad) begin
                        cmd.emit_bad_len = 1'b1;
                        state_next       = PH_SYNC;
                    end else begin
                        cmd.ld_len = 1'b1;
                        state_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (acc) begin
                    cmd.ld_byte = 1'b1;
                    if (stat.len_full) begin
                        state_next = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                if (acc) begin
                    if (stat.crc_match) begin
                        cmd.start_replay = 1'b1;
                        state_next       = PH_REPLAY;
                    end else begin
                        cmd.emit_crc_err = 1'b1;
                        state_next       = PH_SYNC;
                    end
                end
            end
            PH_REPLAY: begin
                if (stat.out_free) begin
                    cmd.emit_byte = 1'b1;
                    if (stat.replay_last) begin
                        state_next = PH_SYNC;
                    end
                end
            end
            default: begin
                state_next = PH_SYNC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_SYNC;
        end else begin
            state_reg <= state_next;
        end
    end

    a_no_accept_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PH_REPLAY) |-> !s_ready)
        else $error("input accepted during payload replay");

    a_emit_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_bad_len, cmd.emit_crc_err, cmd.emit_byte}))
        else $error("two results loaded in one cycle");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_bad_len || cmd.emit_crc_err || cmd.emit_byte) |-> stat.out_free)
        else $error("result loaded while output register is held");

    a_crc_err_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_crc_err |=> (state_reg == PH_SYNC))
        else $error("no return to sync hunt after CRC mismatch");

endmodule

/* src/crc8fr_dp.sv */
// Datapath of the CRC-8 frame receiver: configuration, frame fields, payload
// store, running CRC and the output register. Depends on crc8fr_pkg.
module crc8fr_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_addr,
    input  logic [7:0]                      cfg_wr_data,
    input  logic [7:0]                      s_rx_byte,
    input  crc8fr_pkg::ctrl_cmd_t           cmd,
    output crc8fr_pkg::dp_stat_t            stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crc8fr_pkg::STATUS_W-1:0] m_status,
    output logic [7:0]                      m_frame_kind,
    output logic [crc8fr_pkg::COUNT_W-1:0]  m_payload_count,
    output logic [7:0]                      m_data_value,
    output logic [crc8fr_pkg::POS_W-1:0]    m_data_position,
    output logic                            m_is_switch_notice,
    output logic                            m_last
);
    import crc8fr_pkg::*;

    logic [7:0]          sync_value_reg;
    logic [7:0]          crc_seed_reg;
    logic [7:0]          switch_type_reg;

    logic [7:0]          held_kind_reg;
    logic [CNT_W-1:0]    held_count_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [7:0]          crc_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [7:0]          store_reg [MAX_PAYLOAD];

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [7:0]          out_kind_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [7:0]          out_data_reg;
    logic [POS_W-1:0]    out_pos_reg;
    logic                out_switch_reg;
    logic                out_last_reg;

    logic                emit_any;

    always_comb begin
        stat.sync_hit    = (s_rx_byte == sync_value_reg);
        stat.len_bad     = (s_rx_byte == 8'd0) || (s_rx_byte > 8'(MAX_PAYLOAD));
        stat.len_full    = ((fill_reg + CNT_W'(1)) >= held_count_reg);
        stat.crc_match   = (s_rx_byte == crc_reg);
        stat.replay_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == held_count_reg);
        stat.out_free    = !out_valid_reg || m_ready;
    end

    assign emit_any = cmd.emit_bad_len || cmd.emit_crc_err || cmd.emit_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg  <= SYNC_VALUE_RST;
            crc_seed_reg    <= CRC_SEED_RST;
            switch_type_reg <= SWITCH_TYPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SYNC_VALUE:  sync_value_reg  <= cfg_wr_data;
                REG_CRC_SEED:    crc_seed_reg    <= cfg_wr_data;
                REG_SWITCH_TYPE: switch_type_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Frame fields, CRC and replay pointer carry no reset: every frame loads them first.
    always_ff @(posedge aclk) begin
        if (cmd.ld_kind) begin
            held_kind_reg <= s_rx_byte;
        end
        if (cmd.ld_len) begin
            held_count_reg <= s_rx_byte[CNT_W-1:0];
            fill_reg       <= '0;
            crc_reg        <= crc_seed_reg;
        end
        if (cmd.ld_byte) begin
            store_reg[fill_reg[IDX_W-1:0]] <= s_rx_byte;
            crc_reg                        <= crc8_step(crc_reg, s_rx_byte);
            fill_reg                       <= fill_reg + CNT_W'(1);
        end
        if (cmd.start_replay) begin
            rd_idx_reg <= '0;
        end else if (cmd.emit_byte) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit_any) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_any) begin
            out_kind_reg   <= held_kind_reg;
            out_switch_reg <= (held_kind_reg == switch_type_reg);
        end
        if (cmd.emit_bad_len) begin
            out_status_reg <= STATUS_BAD_LEN;
            out_count_reg  <= '0;
            out_data_reg   <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_crc_err) begin
            out_status_reg <= STATUS_CRC_ERR;
            out_count_reg  <= COUNT_W'(held_count_reg);
            out_data_reg   <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit_byte) begin
            out_status_reg <= STATUS_GOOD;
            out_count_reg  <= COUNT_W'(held_count_reg);
            out_data_reg   <= store_reg[rd_idx_reg];
            out_pos_reg    <= POS_W'(rd_idx_reg);
            out_last_reg   <= stat.replay_last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_status           = out_status_reg;
    assign m_frame_kind       = out_kind_reg;
    assign m_payload_count    = out_count_reg;
    assign m_data_value       = out_data_reg;
    assign m_data_position    = out_pos_reg;
    assign m_is_switch_notice = out_switch_reg;
    assign m_last             = out_last_reg;

    a_store_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_byte |-> (fill_reg < CNT_W'(MAX_PAYLOAD)))
        else $error("payload byte stored beyond the frame length limit");

    a_replay_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_byte |-> (CNT_W'(rd_idx_reg) < held_count_reg))
        else $error("replay pointer past the frame length");

endmodule

/* src/crc8_frame_receiver_core.sv */
// Top level of the CRC-8 frame receiver; depends on crc8fr_pkg, crc8fr_ctrl and crc8fr_dp.
// An error word appears the cycle after the word that causes it is taken; the first payload
// word of a good frame follows its CRC word through the replay state and output register.
// Input: one word per cycle while parsing and the output register is free; a good frame then
// holds the input during payload replay, one word per cycle unless the output stalls.
// Reset: synchronous, active-low aresetn restores config, output valid and the sync hunt.
module crc8_frame_receiver_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_addr,
    input  logic [7:0]                      cfg_wr_data,
    // Received word stream.
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    // Result stream.
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [crc8fr_pkg::STATUS_W-1:0] m_status,
    output logic [7:0]                      m_frame_kind,
    output logic [crc8fr_pkg::COUNT_W-1:0]  m_payload_count,
    output logic [7:0]                      m_data_value,
    output logic [crc8fr_pkg::POS_W-1:0]    m_data_position,
    output logic                            m_is_switch_notice,
    output logic                            m_last
);
    import crc8fr_pkg::*;

    // The controller sequences the frame fields and the replay; the datapath holds
    // all data, compares incoming words against the sync value, length bounds and
    // running CRC, and reports those outcomes back as status.
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    crc8fr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The output register in the datapath separates the two channels, so a new
    // word can be taken in the same cycle a finished result is taken downstream.
    crc8fr_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .s_rx_byte          (s_rx_byte),
        .cmd                (cmd),
        .stat               (stat),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_frame_kind       (m_frame_kind),
        .m_payload_count    (m_payload_count),
        .m_data_value       (m_data_value),
        .m_data_position    (m_data_position),
        .m_is_switch_notice (m_is_switch_notice),
        .m_last             (m_last)
    );

endmodule
